@@ design/sbc_pkg.sv @@
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types, constants and the quarter-wave sine table of the commutator.
// ----------------------------------------------------------------------------
package sbc_pkg;

	localparam int ANGLE_BITS      = 16;
	localparam int SINE_TABLE_BITS = 10;
	localparam int INNER_BITS      = ANGLE_BITS - 2;
	localparam int IDX_W           = SINE_TABLE_BITS + 1;
	localparam int QTR_FULL        = 1 << SINE_TABLE_BITS;
	localparam int ROT_BITS        = 32;
	localparam int MAG_W           = 17;
	localparam int AMP_ONE         = 65536;
	localparam int MUL_A_W         = 33;
	localparam int MUL_B_W         = 20;
	localparam int MUL_P_W         = MUL_A_W + MUL_B_W;
	localparam int DUTY_SUM_W      = 50;
	localparam int UP_SH           = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
	localparam int DN_SH           = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;
	localparam int THIRD           = ((1 << ANGLE_BITS) + 1) / 3;
	localparam int TWO_THIRDS      = ((2 << ANGLE_BITS) + 1) / 3;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef logic [ANGLE_BITS-1:0] angle_t;
	typedef logic [MAG_W-1:0]      sine_mag_t;
	typedef sine_mag_t             sine_rom_t [0:QTR_FULL];

	typedef enum logic [2:0] {
		REG_VMODE,
		REG_VSTEP,
		REG_AMP,
		REG_DUTY_MAX,
		REG_POLES,
		REG_OFFSET,
		REG_LEAD
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VMUL,
		ST_VACC,
		ST_PMUL,
		ST_LOOK,
		ST_SCALE,
		ST_DUTY,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic   en;
		angle_t angle;
	} rom_req_t;

	typedef struct packed {
		logic               en;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	function automatic angle_t from16(logic [15:0] x);
		logic [ANGLE_BITS+15:0] w;
		w = ({{ANGLE_BITS{1'b0}}, x} << UP_SH) >> DN_SH;
		return w[ANGLE_BITS-1:0];
	endfunction

	function automatic logic [15:0] to16(angle_t a);
		logic [ANGLE_BITS+15:0] w;
		w = ({16'd0, a} << DN_SH) >> UP_SH;
		return w[15:0];
	endfunction

	function automatic sine_mag_t quarter_sine(int unsigned i);
		logic [63:0] theta;
		logic [63:0] th2;
		logic [63:0] term;
		longint      sum;
		longint      r;
		int          k;
		theta = (64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
		th2   = (theta * theta) >> 30;
		term  = theta;
		sum   = longint'(theta);
		for (k = 1; k <= 7; k++) begin
			term = (term * th2) >> 30;
			unique case (k)
				1: term = term / 6;
				2: term = term / 20;
				3: term = term / 42;
				4: term = term / 72;
				5: term = term / 110;
				6: term = term / 156;
				default: term = term / 210;
			endcase
			if ((k & 1) == 1)
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		r = (sum + 8192) >>> 14;
		if (r > AMP_ONE)
			r = AMP_ONE;
		return MAG_W'(r);
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t t;
		for (int unsigned i = 0; i <= QTR_FULL; i++)
			t[i] = quarter_sine(i);
		return t;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

@@ design/sinusoidal_bldc_commutator.sv @@
// ----------------------------------------------------------------------------
// sinusoidal_bldc_commutator
// Three-phase sinusoidal duty generator sharing one multiplier and sine table.
// ----------------------------------------------------------------------------
// Each item passes through the multiply, lookup, scale and duty states; velocity
// mode adds the rotor step first. The shared multiplier is used 7 or 8 times per item.
// A new item is accepted only in the idle state, after the previous result is loaded.
// The first item after reset only arms the block and produces no output.
// Reset clears state, virtual rotor and config registers to their defaults.
module sinusoidal_bldc_commutator import sbc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // rotor_angle[15:0], elapsed_us[35:16], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata   // duty_u[15:0], duty_v[31:16], duty_w[47:32], drive_angle[63:48]
);

	logic                vmode_q;
	logic [31:0]         vstep_q;
	logic [16:0]         amp_q;
	logic [15:0]         dmax_q;
	logic [6:0]          poles_q;
	logic [15:0]         offset_q;
	logic [15:0]         lead_q;

	state_t              st_q, st_d;
	logic                armed_q;
	logic [ROT_BITS-1:0] vr_q;
	logic [1:0]          ph_q, ph_d;
	angle_t              elec_q;
	logic                neg_q;
	logic [15:0]         duty_q [0:1];
	logic [15:0]         rotor_q;
	logic [19:0]         elapsed_q;
	logic [63:0]         out_q;
	logic                out_vld_q;

	logic                acc;
	logic                load;
	logic                cap;
	mul_req_t            mreq;
	rom_req_t            rreq;
	logic [MUL_P_W-1:0]  prod;
	sine_mag_t           rmag;
	logic                rneg;
	angle_t              mech;
	angle_t              elec_now;
	angle_t              next_off;
	logic [1:0]          ph_next;
	logic [1:0]          ph_prev;
	logic [16:0]         amp_clamp;
	logic [DUTY_SUM_W-1:0] duty_sum;
	logic [15:0]         duty_val;

	sbc_mul u_mul (
		.clk  (clk),
		.req  (mreq),
		.prod (prod)
	);

	sbc_sine_rom u_rom (
		.clk (clk),
		.req (rreq),
		.mag (rmag),
		.neg (rneg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vmode_q  <= 1'b0;
			vstep_q  <= 32'd0;
			amp_q    <= 17'd19661;
			dmax_q   <= 16'd62259;
			poles_q  <= 7'd7;
			offset_q <= 16'd5824;
			lead_q   <= 16'd16384;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_VMODE:    vmode_q  <= cfg_data[0];
				REG_VSTEP:    vstep_q  <= cfg_data;
				REG_AMP:      amp_q    <= cfg_data[16:0];
				REG_DUTY_MAX: dmax_q   <= cfg_data[15:0];
				REG_POLES:    poles_q  <= cfg_data[6:0];
				REG_OFFSET:   offset_q <= cfg_data[15:0];
				REG_LEAD:     lead_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		mech      = vmode_q ? vr_q[ROT_BITS-1 -: ANGLE_BITS]
			: angle_t'(from16(rotor_q) - from16(offset_q));
		elec_now  = angle_t'(prod[ANGLE_BITS-1:0] + from16(lead_q));
		amp_clamp = (amp_q > 17'(AMP_ONE)) ? 17'(AMP_ONE) : amp_q;
		ph_next   = ph_q + 2'd1;
		ph_prev   = ph_q - 2'd1;
		unique case (ph_next)
			2'd1:    next_off = angle_t'(THIRD);
			2'd2:    next_off = angle_t'(TWO_THIRDS);
			default: next_off = '0;
		endcase
		if (neg_q)
			duty_sum = {2'b00, dmax_q, 32'd0} + DUTY_SUM_W'(64'h1_0000_0000)
				- DUTY_SUM_W'(prod[48:0]);
		else
			duty_sum = {2'b00, dmax_q, 32'd0} + DUTY_SUM_W'(64'h1_0000_0000)
				+ DUTY_SUM_W'(prod[48:0]);
		duty_val = duty_sum[48:33];
	end

	always_comb begin
		st_d     = st_q;
		ph_d     = ph_q;
		s_tready = 1'b0;
		mreq     = '0;
		rreq     = '0;
		load     = 1'b0;
		cap      = 1'b0;
		acc      = s_tvalid && (st_q == ST_IDLE);
		unique case (st_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (acc && armed_q)
					st_d = vmode_q ? ST_VMUL : ST_PMUL;
			end
			ST_VMUL: begin
				mreq.en = 1'b1;
				mreq.a  = MUL_A_W'(vstep_q);
				mreq.b  = elapsed_q;
				st_d    = ST_VACC;
			end
			ST_VACC: begin
				st_d = ST_PMUL;
			end
			ST_PMUL: begin
				mreq.en = 1'b1;
				mreq.a  = MUL_A_W'(mech);
				mreq.b  = MUL_B_W'(poles_q);
				st_d    = ST_LOOK;
			end
			ST_LOOK: begin
				rreq.en    = 1'b1;
				rreq.angle = elec_now;
				ph_d       = 2'd0;
				st_d       = ST_SCALE;
			end
			ST_SCALE: begin
				mreq.en = 1'b1;
				mreq.a  = MUL_A_W'(rmag);
				mreq.b  = MUL_B_W'(amp_clamp);
				cap     = (ph_q != 2'd0);
				st_d    = ST_DUTY;
			end
			ST_DUTY: begin
				mreq.en = 1'b1;
				mreq.a  = prod[MUL_A_W-1:0];
				mreq.b  = MUL_B_W'(dmax_q);
				if (ph_q != 2'd2) begin
					rreq.en    = 1'b1;
					rreq.angle = angle_t'(elec_q - next_off);
					ph_d       = ph_next;
					st_d       = ST_SCALE;
				end else begin
					st_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_vld_q || m_tready) begin
					load = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			ph_q      <= 2'd0;
			armed_q   <= 1'b0;
			vr_q      <= '0;
			out_vld_q <= 1'b0;
		end else begin
			st_q <= st_d;
			ph_q <= ph_d;
			if (acc)
				armed_q <= 1'b1;
			if (st_q == ST_VACC)
				vr_q <= vr_q + prod[ROT_BITS-1:0];
			if (load)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rotor_q   <= s_tdata[15:0];
			elapsed_q <= s_tdata[35:16];
		end
		if (st_q == ST_LOOK)
			elec_q <= elec_now;
		if (st_q == ST_SCALE)
			neg_q <= rneg;
		if (cap)
			duty_q[ph_prev[0]] <= duty_val;
		if (load)
			out_q <= {to16(elec_q), duty_val, duty_q[1], duty_q[0]};
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	a_arm_first: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !armed_q |=> armed_q && st_q == ST_IDLE)
		else $error("first item did not just arm the block");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		ph_q != 2'd3)
		else $error("phase counter out of range");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_FIN && m_tvalid && !m_tready |=> st_q == ST_FIN)
		else $error("pending result overwritten");

	a_rotor_hold: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_VACC |=> $stable(vr_q))
		else $error("virtual rotor moved outside accumulate step");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(st_q) == ST_FIN)
		else $error("result raised outside finish step");

endmodule

@@ design/sbc_sine_rom.sv @@
// ----------------------------------------------------------------------------
// sbc_sine_rom
// Quadrant folding and registered lookup into the quarter-wave sine table.
// ----------------------------------------------------------------------------
module sbc_sine_rom import sbc_pkg::*; (
	input  logic      clk,
	input  rom_req_t  req,
	output sine_mag_t mag,
	output logic      neg
);

	localparam int SH_DN = (INNER_BITS >= SINE_TABLE_BITS) ? INNER_BITS - SINE_TABLE_BITS : 0;
	localparam int SH_UP = (INNER_BITS >= SINE_TABLE_BITS) ? 0 : SINE_TABLE_BITS - INNER_BITS;

	logic [1:0]                  quad;
	logic [INNER_BITS-1:0]       pos;
	logic [INNER_BITS+IDX_W-1:0] wide;
	logic [IDX_W-1:0]            idx;
	sine_mag_t                   mag_q;
	logic                        neg_q;

	always_comb begin
		quad = req.angle[ANGLE_BITS-1 -: 2];
		pos  = req.angle[INNER_BITS-1:0];
		wide = ({{IDX_W{1'b0}}, pos} >> SH_DN) << SH_UP;
		idx  = wide[IDX_W-1:0];
		if (quad[0])
			idx = IDX_W'(QTR_FULL) - idx;
	end

	always_ff @(posedge clk) begin
		if (req.en) begin
			mag_q <= SINE_ROM[idx];
			neg_q <= quad[1];
		end
	end

	assign mag = mag_q;
	assign neg = neg_q;

endmodule

@@ design/sbc_mul.sv @@
// ----------------------------------------------------------------------------
// sbc_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module sbc_mul import sbc_pkg::*; (
	input  logic               clk,
	input  mul_req_t           req,
	output logic [MUL_P_W-1:0] prod
);

	logic [MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en)
			prod_q <= MUL_P_W'(req.a) * MUL_P_W'(req.b);
	end

	assign prod = prod_q;

endmodule

@@ tb/sinusoidal_bldc_commutator_tb.sv @@
// ----------------------------------------------------------------------------
// sinusoidal_bldc_commutator_tb
// Self-checking bench for the three-phase sinusoidal duty generator. Rotor
// samples stream in with bursty timing while the result side stalls on its
// own pattern. A scoreboard keeps its own sine table, virtual rotor and
// register copy. It predicts the duty set of every sample after the arming one and
// compares each result transfer field by field. A short directed pass covers the
// extremes, both modes and the arming sample. Randomized register settings follow.
// ----------------------------------------------------------------------------
module sinusoidal_bldc_commutator_tb import sbc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0]  CFG_SPARE       = 3'd7;
	localparam logic [15:0] THIRD_TURN      = 16'd21845;
	localparam logic [15:0] TWO_THIRDS_TURN = 16'd43691;
	localparam logic [63:0] QTR_PI_Q30      = 64'd1686629713;
	localparam int          SETTLE_CYCLES   = 16;
	localparam int          PHASE_ITEMS     = 55;
	localparam int          RANDOM_PHASES   = 10;

	typedef struct packed {
		logic [15:0] drive_angle;
		logic [15:0] duty_w;
		logic [15:0] duty_v;
		logic [15:0] duty_u;
	} duty_set_t;

	class commutation_board;
		int          sine_q16 [0:1024];
		duty_set_t   expected_q [$];
		logic        vmode;
		logic [31:0] vstep;
		logic [16:0] amp;
		logic [15:0] duty_max;
		logic [6:0]  poles;
		logic [15:0] offset;
		logic [15:0] lead;
		logic        armed;
		logic [31:0] vrot;
		int          items;
		int          results;
		int          failures;

		function new();
			vmode    = 1'b0;
			vstep    = 32'd0;
			amp      = 17'd19661;
			duty_max = 16'd62259;
			poles    = 7'd7;
			offset   = 16'd5824;
			lead     = 16'd16384;
			armed    = 1'b0;
			vrot     = 32'd0;
			items    = 0;
			results  = 0;
			failures = 0;
			build_table();
		endfunction

		// quarter-wave sine in Q1.16 from an eight-term Taylor series in Q2.30
		function void build_table();
			logic [63:0] theta;
			logic [63:0] th2;
			logic [63:0] term;
			longint      acc;
			longint      r;
			for (int i = 0; i <= 1024; i++) begin
				theta = (64'(i) * QTR_PI_Q30) >> 10;
				th2   = (theta * theta) >> 30;
				term  = theta;
				acc   = theta;
				for (int k = 1; k <= 7; k++) begin
					term = ((term * th2) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
					if (k % 2 == 1)
						acc = acc - term;
					else
						acc = acc + term;
				end
				if (acc < 0)
					acc = 0;
				r = (acc + 8192) >>> 14;
				if (r > 65536)
					r = 65536;
				sine_q16[i] = int'(r);
			end
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (cfg_reg_t'(idx))
				REG_VMODE:    vmode    = val[0];
				REG_VSTEP:    vstep    = val;
				REG_AMP:      amp      = val[16:0];
				REG_DUTY_MAX: duty_max = val[15:0];
				REG_POLES:    poles    = val[6:0];
				REG_OFFSET:   offset   = val[15:0];
				REG_LEAD:     lead     = val[15:0];
				default: ;
			endcase
		endfunction

		function logic [15:0] duty_at(logic [15:0] a);
			int unsigned     idx;
			longint          sv;
			longint          amp_eff;
			longint unsigned frac2;
			longint unsigned num;
			idx = a[13:4];
			if (a[14])
				idx = 1024 - idx;
			sv = sine_q16[idx];
			if (a[15])
				sv = -sv;
			if (amp > 17'd65536)
				amp_eff = 65536;
			else
				amp_eff = amp;
			frac2 = sv * amp_eff + 64'sd4294967296;
			num   = frac2 * duty_max + 64'd4294967296;
			return 16'(num >> 33);
		endfunction

		function void note_sample(logic [15:0] rotor, logic [19:0] el);
			logic [15:0] mech;
			logic [15:0] elec;
			logic [31:0] sum;
			duty_set_t   d;
			items++;
			if (!armed) begin
				armed = 1'b1;
				return;
			end
			if (vmode) begin
				vrot = vrot + vstep * el;
				mech = vrot[31:16];
			end else begin
				mech = rotor - offset;
			end
			sum           = mech * poles + lead;
			elec          = sum[15:0];
			d.duty_u      = duty_at(elec);
			d.duty_v      = duty_at(elec - THIRD_TURN);
			d.duty_w      = duty_at(elec - TWO_THIRDS_TURN);
			d.drive_angle = elec;
			expected_q.push_back(d);
		endfunction

		function void check_duty(logic [63:0] word);
			duty_set_t got;
			duty_set_t want;
			got = word;
			results++;
			if (expected_q.size() == 0) begin
				$error("unexpected result transfer %h", word);
				failures++;
				return;
			end
			want = expected_q.pop_front();
			if (got.duty_u !== want.duty_u) begin
				$error("duty_u expected %0d actual %0d", want.duty_u, got.duty_u);
				failures++;
			end
			if (got.duty_v !== want.duty_v) begin
				$error("duty_v expected %0d actual %0d", want.duty_v, got.duty_v);
				failures++;
			end
			if (got.duty_w !== want.duty_w) begin
				$error("duty_w expected %0d actual %0d", want.duty_w, got.duty_w);
				failures++;
			end
			if (got.drive_angle !== want.drive_angle) begin
				$error("drive_angle expected %0d actual %0d", want.drive_angle,
					got.drive_angle);
				failures++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void close_out();
			if (expected_q.size() != 0) begin
				$error("%0d duty sets never arrived", expected_q.size());
				failures++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // rotor_angle[15:0], elapsed_us[35:16], zero pad
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;   // duty_u[15:0], duty_v[31:16], duty_w[47:32], drive_angle[63:48]

	commutation_board sb = new();
	int burst_left = 0;
	int n_writes   = 0;
	int n_settings = 0;

	sinusoidal_bldc_commutator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int cyc;
		int mode;
		m_tready <= 1'b0;
		cyc  = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (cyc % 48 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (cyc % 8 == 7);
				default: m_tready <= (cyc % 16 < 11);
			endcase
			cyc++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_duty(m_tdata);
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_reg(idx, val);
		n_writes++;
		@(posedge clk);
	endtask

	task automatic send_item(input logic [15:0] rotor, input logic [19:0] el);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, el, rotor};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_sample(rotor, el);
	endtask

	// drop valid and let the pipeline empty before touching registers
	task automatic drain();
		int n;
		s_tvalid  <= 1'b0;
		burst_left = 0;
		n = 0;
		while (sb.pending() != 0 && n < 5000) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] with_junk(logic [31:0] v, int width);
		if ($urandom_range(0, 3) == 0)
			return v | (32'($urandom) << width);
		return v;
	endfunction

	task automatic random_setup();
		logic [31:0] v;
		n_settings++;
		write_reg(REG_VMODE, with_junk($urandom_range(0, 1), 1));
		case ($urandom_range(0, 4))
			0: v = 32'h7FFF_FFFF;
			1: v = 32'h8000_0000;
			2: v = $urandom;
			default: begin
				v = $urandom >> $urandom_range(8, 31);
				if ($urandom_range(0, 1))
					v = -v;
			end
		endcase
		write_reg(REG_VSTEP, v);
		case ($urandom_range(0, 5))
			0: v = 0;
			1: v = 65536;
			2: v = 131071;
			3: v = $urandom_range(65537, 131071);
			default: v = $urandom_range(0, 65536);
		endcase
		write_reg(REG_AMP, with_junk(v, 17));
		case ($urandom_range(0, 4))
			0: v = 0;
			1: v = 65535;
			default: v = $urandom_range(0, 65535);
		endcase
		write_reg(REG_DUTY_MAX, with_junk(v, 16));
		case ($urandom_range(0, 7))
			0: v = 0;
			1: v = 127;
			2: v = 64;
			3: v = 1;
			4: v = $urandom_range(65, 127);
			default: v = $urandom_range(1, 64);
		endcase
		write_reg(REG_POLES, with_junk(v, 7));
		write_reg(REG_OFFSET, with_junk($urandom_range(0, 65535), 16));
		write_reg(REG_LEAD, with_junk($urandom_range(0, 65535), 16));
		if ($urandom_range(0, 2) == 0)
			write_reg(CFG_SPARE, $urandom);
	endtask

	initial begin
		logic [19:0] el;
		arst_n = 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, position mode; the first transfer only arms
		n_settings++;
		send_item(16'hFFFF, 20'hFFFFF);
		send_item(16'h0000, 20'h00000);
		send_item(16'hFFFF, 20'hFFFFF);
		send_item(16'd5824, 20'd1);
		send_item(16'd5823, 20'd2);
		drain();

		// velocity mode at full forward speed, full drive, no offset
		n_settings++;
		write_reg(REG_VMODE, 32'd1);
		write_reg(REG_VSTEP, 32'h7FFF_FFFF);
		write_reg(REG_AMP, 32'd65536);
		write_reg(REG_DUTY_MAX, 32'd65535);
		write_reg(REG_POLES, 32'd64);
		write_reg(REG_OFFSET, 32'd0);
		write_reg(REG_LEAD, 32'd0);
		write_reg(CFG_SPARE, 32'hFFFF_FFFF);
		send_item(16'h1234, 20'hFFFFF);
		send_item(16'h0000, 20'h00000);
		send_item(16'hFFFF, 20'h00001);
		send_item(16'h8000, 20'hFFFFF);
		drain();

		// full reverse speed, amplitude over one, zero ceiling, zero pole pairs
		n_settings++;
		write_reg(REG_VSTEP, 32'h8000_0000);
		write_reg(REG_AMP, 32'd131071);
		write_reg(REG_DUTY_MAX, 32'd0);
		write_reg(REG_POLES, 32'd0);
		write_reg(REG_LEAD, 32'd65535);
		send_item(16'h0000, 20'hFFFFF);
		send_item(16'h5555, 20'd12345);
		send_item(16'hAAAA, 20'h00000);
		drain();

		// back to position mode, zero amplitude, largest pole count
		n_settings++;
		write_reg(REG_VMODE, 32'd0);
		write_reg(REG_AMP, 32'd0);
		write_reg(REG_DUTY_MAX, 32'd65535);
		write_reg(REG_POLES, 32'd127);
		write_reg(REG_OFFSET, 32'd65535);
		write_reg(REG_LEAD, 32'd0);
		send_item(16'h0000, 20'd7);
		send_item(16'hFFFF, 20'd7);
		send_item(16'h8000, 20'd7);
		send_item(16'h4000, 20'd7);
		drain();

		// single pole pair: walk across the quadrant boundaries of the sine
		n_settings++;
		write_reg(REG_POLES, 32'd1);
		write_reg(REG_AMP, 32'd65535);
		write_reg(REG_OFFSET, 32'd0);
		send_item(16'h3FFF, 20'd0);
		send_item(16'h4000, 20'd0);
		send_item(16'h7FF0, 20'd0);
		send_item(16'h8000, 20'd0);
		send_item(16'hC000, 20'd0);
		send_item(16'hFFF0, 20'd0);
		drain();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_setup();
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				case ($urandom_range(0, 5))
					0: el = 20'hFFFFF;
					1: el = 20'h00000;
					2: el = $urandom_range(0, 1000);
					default: el = $urandom_range(0, 20'hFFFFF);
				endcase
				send_item(16'($urandom_range(0, 65535)), el);
			end
			drain();
		end

		sb.close_out();
		$display("Covered %0d input transfers and %0d duty sets over %0d register settings",
			sb.items, sb.results, n_settings);
		$display("(%0d register writes, position and velocity modes)", n_writes);
		if (sb.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
